### rtl/ept_pkg.sv
// ----------------------------------------------------------------------------
// ept_pkg
// Shared widths, codes and types of the epoch parameter tuner with retreat.
// ----------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

	localparam int TIME_W     = 48;
	localparam int COUNT_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = COUNT_W + FRAC_W;
	localparam int EPOCH_W    = 24;
	localparam int MEAS_W     = 8;
	localparam int RETR_W     = 3;
	localparam int TOTAL_W    = 32;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int MODE_W     = 2;
	localparam int CMD_W      = 3;
	localparam int CTRL_W     = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_EPOCH_LENGTH    = 3'd0;
	localparam cfg_idx_t CFG_RETREAT_START   = 3'd1;
	localparam cfg_idx_t CFG_RETREAT_END     = 3'd2;
	localparam cfg_idx_t CFG_EMERGENCY_START = 3'd3;
	localparam cfg_idx_t CFG_INIT_MEAS       = 3'd4;
	localparam cfg_idx_t CFG_RETREAT_MEAS    = 3'd5;
	localparam cfg_idx_t CFG_MAX_RETREATS    = 3'd6;

	localparam logic [EPOCH_W-1:0] EPOCH_LENGTH_RST    = 24'd1000;
	localparam logic [FRAC_W-1:0]  RETREAT_START_RST   = 16'd22938;
	localparam logic [FRAC_W-1:0]  RETREAT_END_RST     = 16'd39322;
	localparam logic [FRAC_W-1:0]  EMERGENCY_START_RST = 16'd16384;
	localparam logic [MEAS_W-1:0]  INIT_MEAS_RST       = 8'd4;
	localparam logic [MEAS_W-1:0]  RETREAT_MEAS_RST    = 8'd4;
	localparam logic [RETR_W-1:0]  MAX_RETREATS_RST    = 3'd5;

	localparam logic [MODE_W-1:0] MODE_POLL       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACTIVATE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEACTIVATE = 2'd2;

	localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_NEW_TARGET = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REVERT     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTORE    = 3'd4;

	localparam logic [CTRL_W-1:0] CTRL_OFF     = 3'd0;
	localparam logic [CTRL_W-1:0] CTRL_INIT    = 3'd1;
	localparam logic [CTRL_W-1:0] CTRL_FIND    = 3'd2;
	localparam logic [CTRL_W-1:0] CTRL_EPOCH   = 3'd3;
	localparam logic [CTRL_W-1:0] CTRL_RETREAT = 3'd4;
	localparam logic [CTRL_W-1:0] CTRL_EMERG   = 3'd5;

	localparam logic [RETR_W-1:0] RETR_MAX = '1;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [TIME_W-1:0]  sim_timestep;
		logic [COUNT_W-1:0] active_count;
		logic               target_reached;
	} poll_item_t;

endpackage

`default_nettype wire

### rtl/ept_channels.sv
// ----------------------------------------------------------------------------
// ept channels
// Valid/ready channel interfaces for poll requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ept_poll_if;
	import ept_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [TIME_W-1:0]   sim_timestep;
	logic [COUNT_W-1:0]  active_count;
	logic                target_reached;

	modport source (output valid, mode, sim_timestep, active_count, target_reached,
		input ready);
	modport sink (input valid, mode, sim_timestep, active_count, target_reached,
		output ready);
endinterface

interface ept_result_if;
	import ept_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [CTRL_W-1:0]  ctrl_mode;
	logic               measured;
	logic [RETR_W-1:0]  retreat_count;

	modport source (output valid, command, ctrl_mode, measured, retreat_count,
		input ready);
	modport sink (input valid, command, ctrl_mode, measured, retreat_count,
		output ready);
endinterface

`default_nettype wire

### rtl/epoch_parameter_tuner_with_retreat_unit.sv
// ----------------------------------------------------------------------------
// epoch_parameter_tuner_with_retreat_unit
// Supervisory controller: epoch accumulation of timesteps, measurement-driven
// phase machine with retreat and emergency thresholds, one command per poll.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  poll      in   valid/ready    mode, sim_timestep, active_count, target_reached
//  result    out  valid/ready    command, ctrl_mode, measured, retreat_count
//  cfg       in   cfg_we only    cfg_idx, cfg_wdata
//
//  one request per cycle sustained while the result is not stalled; a poll reaches
//  result through the input register, then accumulate/compare/update into the result register
//  threshold products reference*fraction are registered in the cycle after the
//  reference or a fraction register changes
//  asynchronous reset puts the controller off with all counters at zero
//  a stalled result holds the input register, which then holds poll.ready low
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_parameter_tuner_with_retreat_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire ept_pkg::cfg_idx_t           cfg_idx,
	input  wire logic [ept_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ept_poll_if.sink                         poll,
	ept_result_if.source                     result
);
	import ept_pkg::*;

	typedef enum logic [CTRL_W-1:0] {
		PH_OFF     = CTRL_OFF,
		PH_INIT    = CTRL_INIT,
		PH_FIND    = CTRL_FIND,
		PH_EPOCH   = CTRL_EPOCH,
		PH_RETREAT = CTRL_RETREAT,
		PH_EMERG   = CTRL_EMERG
	} phase_t;

	// configuration
	logic [EPOCH_W-1:0] epoch_len_q;
	logic [FRAC_W-1:0]  rs_q16_q;
	logic [FRAC_W-1:0]  re_q16_q;
	logic [FRAC_W-1:0]  es_q16_q;
	logic [MEAS_W-1:0]  init_meas_q;
	logic [MEAS_W-1:0]  ret_meas_q;
	logic [RETR_W-1:0]  max_ret_q;

	// controller state
	phase_t             phase_q, phase_d;
	logic [TIME_W-1:0]  last_time_q, last_time_d;
	logic               last_valid_q, last_valid_d;
	logic [TIME_W-1:0]  acc_q, acc_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic [TOTAL_W-1:0] mark_q, mark_d;
	logic [RETR_W-1:0]  retreats_q, retreats_d;
	logic [COUNT_W-1:0] ref_q, ref_d;

	// threshold products
	logic [PROD_W-1:0]  thr_rs_q;
	logic [PROD_W-1:0]  thr_re_q;
	logic [PROD_W-1:0]  thr_es_q;

	// pipeline
	logic               valid_s1;
	poll_item_t         item_s1;
	logic               out_valid_q;
	logic [CMD_W-1:0]   command_q;
	logic [CTRL_W-1:0]  ctrl_mode_q;
	logic               measured_q;
	logic [RETR_W-1:0]  retreat_count_q;

	logic               advance;
	logic [CMD_W-1:0]   cmd;
	logic               fired;
	logic [TIME_W-1:0]  diff;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  acc_sat;
	logic               over;
	logic [TOTAL_W-1:0] total_inc;
	logic [PROD_W-1:0]  active_sh;
	logic               below_rs;
	logic               below_es;
	logic               above_re;
	logic               mark_done;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	assign result.valid         = out_valid_q;
	assign result.command       = command_q;
	assign result.ctrl_mode     = ctrl_mode_q;
	assign result.measured      = measured_q;
	assign result.retreat_count = retreat_count_q;

	always_comb begin
		diff      = item_s1.sim_timestep - last_time_q;
		sum       = {1'b0, acc_q} + {1'b0, diff};
		acc_sat   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
		over      = acc_sat > TIME_W'(epoch_len_q);
		total_inc = (total_q == {TOTAL_W{1'b1}}) ? total_q : total_q + 1'b1;
		active_sh = {item_s1.active_count, {FRAC_W{1'b0}}};
		below_rs  = active_sh < thr_rs_q;
		below_es  = active_sh < thr_es_q;
		above_re  = active_sh > thr_re_q;
		mark_done = ({1'b0, mark_q} + (TOTAL_W+1)'(ret_meas_q)) < {1'b0, total_inc};

		phase_d      = phase_q;
		last_time_d  = last_time_q;
		last_valid_d = last_valid_q;
		acc_d        = acc_q;
		total_d      = total_q;
		mark_d       = mark_q;
		retreats_d   = retreats_q;
		ref_d        = ref_q;
		cmd          = CMD_NONE;
		fired        = 1'b0;

		case (item_s1.mode)
			MODE_ACTIVATE: begin
				phase_d      = PH_INIT;
				retreats_d   = '0;
				last_valid_d = 1'b0;
				last_time_d  = '0;
				acc_d        = '0;
				total_d      = '0;
				mark_d       = '0;
			end
			MODE_DEACTIVATE: begin
				phase_d = PH_OFF;
			end
			MODE_POLL: begin
				if (phase_q != PH_OFF) begin
					// backward steps only reload the last timestep
					if (last_valid_q && last_time_q <= item_s1.sim_timestep) begin
						acc_d = acc_sat;
						if (over) begin
							fired   = 1'b1;
							acc_d   = acc_sat - TIME_W'(epoch_len_q);
							total_d = total_inc;
							case (phase_q)
								PH_INIT: begin
									if (total_inc == TOTAL_W'(init_meas_q)) begin
										ref_d   = item_s1.active_count;
										phase_d = PH_FIND;
									end
								end
								PH_FIND: begin
									cmd        = CMD_NEW_TARGET;
									retreats_d = '0;
									phase_d    = PH_EPOCH;
								end
								PH_EPOCH: begin
									if (below_rs) begin
										if (retreats_q != RETR_MAX)
											retreats_d = retreats_q + 1'b1;
										phase_d = PH_RETREAT;
										cmd     = CMD_REVERT;
										mark_d  = total_inc;
									end else begin
										cmd = CMD_ADVANCE;
										if (item_s1.target_reached)
											phase_d = PH_FIND;
									end
								end
								PH_RETREAT: begin
									if (below_es) begin
										phase_d = PH_EMERG;
										cmd     = CMD_RESTORE;
									end
									// end check may still override the emergency phase
									if (above_re || mark_done)
										phase_d = (retreats_q >= max_ret_q) ? PH_FIND : PH_EPOCH;
								end
								PH_EMERG: begin
									if (above_re)
										phase_d = PH_FIND;
								end
								default: ;
							endcase
						end
					end
					last_time_d  = item_s1.sim_timestep;
					last_valid_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_len_q  <= EPOCH_LENGTH_RST;
			rs_q16_q     <= RETREAT_START_RST;
			re_q16_q     <= RETREAT_END_RST;
			es_q16_q     <= EMERGENCY_START_RST;
			init_meas_q  <= INIT_MEAS_RST;
			ret_meas_q   <= RETREAT_MEAS_RST;
			max_ret_q    <= MAX_RETREATS_RST;
			phase_q      <= PH_OFF;
			last_time_q  <= '0;
			last_valid_q <= 1'b0;
			acc_q        <= '0;
			total_q      <= '0;
			mark_q       <= '0;
			retreats_q   <= '0;
			ref_q        <= '0;
			thr_rs_q     <= '0;
			thr_re_q     <= '0;
			thr_es_q     <= '0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			thr_rs_q <= PROD_W'(ref_q) * PROD_W'(rs_q16_q);
			thr_re_q <= PROD_W'(ref_q) * PROD_W'(re_q16_q);
			thr_es_q <= PROD_W'(ref_q) * PROD_W'(es_q16_q);

			if (poll.ready)
				valid_s1 <= poll.valid;

			// an epoch length write clears the accumulator
			if (cfg_we && cfg_idx == CFG_EPOCH_LENGTH)
				acc_q <= '0;
			else if (advance)
				acc_q <= acc_d;

			if (advance) begin
				phase_q      <= phase_d;
				last_time_q  <= last_time_d;
				last_valid_q <= last_valid_d;
				total_q      <= total_d;
				mark_q       <= mark_d;
				retreats_q   <= retreats_d;
				ref_q        <= ref_d;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_idx)
					CFG_EPOCH_LENGTH:    epoch_len_q <= cfg_wdata[EPOCH_W-1:0];
					CFG_RETREAT_START:   rs_q16_q    <= cfg_wdata[FRAC_W-1:0];
					CFG_RETREAT_END:     re_q16_q    <= cfg_wdata[FRAC_W-1:0];
					CFG_EMERGENCY_START: es_q16_q    <= cfg_wdata[FRAC_W-1:0];
					CFG_INIT_MEAS:       init_meas_q <= cfg_wdata[MEAS_W-1:0];
					CFG_RETREAT_MEAS:    ret_meas_q  <= cfg_wdata[MEAS_W-1:0];
					CFG_MAX_RETREATS:    max_ret_q   <= cfg_wdata[RETR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			item_s1.mode           <= poll.mode;
			item_s1.sim_timestep   <= poll.sim_timestep;
			item_s1.active_count   <= poll.active_count;
			item_s1.target_reached <= poll.target_reached;
		end
		if (advance) begin
			command_q       <= cmd;
			ctrl_mode_q     <= phase_d;
			measured_q      <= fired;
			retreat_count_q <= retreats_d;
		end
	end

endmodule

`default_nettype wire

### rtl/ept_checker.sv
// ----------------------------------------------------------------------------
// ept_checker
// Port-level checks on the result channel of the tuner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        res_valid,
	input wire logic                        res_ready,
	input wire logic [ept_pkg::CMD_W-1:0]   command,
	input wire logic [ept_pkg::CTRL_W-1:0]  ctrl_mode,
	input wire logic                        measured,
	input wire logic [ept_pkg::RETR_W-1:0]  retreat_count
);
	import ept_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
			$stable({command, ctrl_mode, measured, retreat_count}))
		else $error("result changed while stalled");

	a_cmd_needs_meas: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !measured |-> command == CMD_NONE)
		else $error("command without a measurement");

	a_new_target: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && command == CMD_NEW_TARGET |-> ctrl_mode == CTRL_EPOCH &&
			retreat_count == '0)
		else $error("new target did not open an epoch");

	a_revert: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && command == CMD_REVERT |-> ctrl_mode == CTRL_RETREAT &&
			retreat_count != '0)
		else $error("revert without retreat");

endmodule

bind epoch_parameter_tuner_with_retreat_unit ept_checker u_ept_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.command       (result.command),
	.ctrl_mode     (result.ctrl_mode),
	.measured      (result.measured),
	.retreat_count (result.retreat_count)
);

`default_nettype wire
